// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the keypad word search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define KW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define KW_ASSERT(lbl, prop, msg)
`define KW_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/kwrs_pkg.sv =====
// Types, constants and the letter-to-digit map for the keypad word search.
`default_nettype none
package kwrs_pkg;

  localparam int MODE_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int ENTRY_W  = 15;
  localparam int POS_W    = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DCNT_W   = 5;
  localparam int CAND_W   = 17;
  localparam int SEL_W    = 16;
  localparam int DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_TWO  = 8'h32;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LA   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LZ   = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_UA   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UZ   = 8'h5a;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_NEXT    = 3'd2,
    MODE_PREV    = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_REFRESH = 3'd5,
    MODE_LOAD    = 3'd6
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BUILTIN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_ENABLE  = 2'd2;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_SRCH_B,
    TS_SRCH_X,
    TS_FIN
  } top_state_t;

  typedef enum logic [2:0] {
    SR_IDLE,
    SR_PICK,
    SR_RD,
    SR_EV,
    SR_DONE
  } srch_state_t;

  typedef struct packed {
    logic go;
    logic table_sel;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } srch_rsp_t;

  localparam logic [DIGIT_W-1:0] LETTER_KEY [26] = '{
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9
  };

  // 0 for anything that is not a letter
  function automatic logic [DIGIT_W-1:0] key_of_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    off = '0;
    if (c >= CHAR_LA && c <= CHAR_LZ) begin
      off = c - CHAR_LA;
      return LETTER_KEY[off[4:0]];
    end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
      off = c - CHAR_UA;
      return LETTER_KEY[off[4:0]];
    end
    return '0;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/keypad_word_run_search_core.sv =====
// Top level: event decode, typed digits, run and selection state, result register.
// Keypad word lookup over a built-in and an extra sorted word table.
// Input channel (in_*): one event word per handshake, taken when in_valid is high and
// in_stall low. Mode selects push, pop, next, previous, clear, refresh or load.
// Result channel (out_*): exactly one result word per event, held in an output register
// until taken (out_valid high, out_stall low).
// Config port (cfg_*): plain write, index 0 builtin count, 1 extra count, 2 extra enable;
// write only while no event is in flight.
// Events without a lookup pass through the finish state into the output register.
// A lookup (push, pop to non-empty, refresh with digits) runs a binary search and a run
// count per table; each probe reads its word one character at a time from the store,
// a read then an evaluate step per character; a table takes about (log2(count)+run+1)
// probes, and an enabled, non-empty extra table is searched after the built-in one.
// One event is in work at a time; in_stall is high while it runs and while a finished
// result waits on a stalled receiver.
// Reset (synchronous, rst_n low) clears digits, runs, selection, config registers and the
// output valid. The character store is not cleared; only written words may be searched.
`default_nettype none
`include "assert_macros.svh"
module keypad_word_run_search_core #(
  parameter int MAX_DIGITS  = 24,
  parameter int TABLE_WORDS = 32768,
  parameter int WORD_CHARS  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kwrs_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [kwrs_pkg::CHAR_W-1:0]       in_key_char,
  input  wire logic                              in_load_table,
  input  wire logic [kwrs_pkg::ENTRY_W-1:0]      in_load_entry,
  input  wire logic [kwrs_pkg::POS_W-1:0]        in_load_position,
  input  wire logic [kwrs_pkg::CHAR_W-1:0]       in_load_char,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_accepted,
  output logic      [kwrs_pkg::DCNT_W-1:0]       out_digit_count,
  output logic      [kwrs_pkg::CAND_W-1:0]       out_candidate_count,
  output logic      [kwrs_pkg::SEL_W-1:0]        out_selection,
  output logic                                   out_has_candidate,
  output logic                                   out_selected_from_extra,
  output logic      [kwrs_pkg::ENTRY_W-1:0]      out_selected_entry,
  input  wire logic                              cfg_we,
  input  wire logic [kwrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kwrs_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int CW    = $clog2(TABLE_WORDS + 1);
  localparam int LW    = $clog2(MAX_DIGITS + 1);
  localparam int DIW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int AW    = $clog2(2 * TABLE_WORDS * WORD_CHARS);
  localparam int DEPTH = 2 * TABLE_WORDS * WORD_CHARS;
  localparam int SW    = $clog2(2 * TABLE_WORDS);
  localparam int XW    = ((SW > CW) ? SW : CW) + 2;
  localparam int CMPW  = 18;

  kwrs_pkg::top_state_t state_r, state_nxt;

  logic [kwrs_pkg::CFG_W-1:0] bcnt_r, xcnt_r;
  logic                       xen_r;

  logic [MAX_DIGITS-1:0][kwrs_pkg::DIGIT_W-1:0] digits_r, digits_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [CW-1:0] bs_r, bs_nxt, bl_r, bl_nxt, xs_r, xs_nxt, xl_r, xl_nxt;
  logic [SW-1:0] sel_r, sel_nxt;
  logic          acc_r, acc_nxt;

  logic                               ov_r;
  logic                               o_acc_r;
  logic [kwrs_pkg::DCNT_W-1:0]        o_dcnt_r;
  logic [kwrs_pkg::CAND_W-1:0]        o_cand_r;
  logic [kwrs_pkg::SEL_W-1:0]         o_sel_r;
  logic                               o_has_r, o_fx_r;
  logic [kwrs_pkg::ENTRY_W-1:0]       o_ent_r;

  logic                    in_acc, push_ok, pop_ok, lookup_req, x_en, fin_go;
  logic [CW-1:0]           b_sat, x_sat;
  kwrs_pkg::srch_req_t     sreq;
  kwrs_pkg::srch_rsp_t     srsp;
  logic [CW-1:0]           s_count, s_start, s_len;
  logic [AW-1:0]           rd_addr, waddr;
  logic [kwrs_pkg::CHAR_W-1:0] rd_data;
  logic                    mem_we;
  logic [XW-1:0]           total, sel_x, ent_x;

  assign in_acc = in_valid && !in_stall;
  assign x_en   = xen_r && (xcnt_r != '0);
  assign b_sat  = (CMPW'(bcnt_r) > CMPW'(TABLE_WORDS)) ? CW'(TABLE_WORDS) : CW'(bcnt_r);
  assign x_sat  = (CMPW'(xcnt_r) > CMPW'(TABLE_WORDS)) ? CW'(TABLE_WORDS) : CW'(xcnt_r);

  always_comb begin
    push_ok    = (in_key_char >= kwrs_pkg::CHAR_TWO) && (in_key_char <= kwrs_pkg::CHAR_NINE)
                 && (len_r < LW'(MAX_DIGITS));
    pop_ok     = (len_r != '0);
    lookup_req = 1'b0;
    case (in_mode)
      kwrs_pkg::MODE_PUSH:    lookup_req = push_ok;
      kwrs_pkg::MODE_POP:     lookup_req = pop_ok && (len_r != LW'(1));
      kwrs_pkg::MODE_REFRESH: lookup_req = pop_ok;
      default:                lookup_req = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kwrs_pkg::TS_IDLE: begin
        if (in_acc) state_nxt = lookup_req ? kwrs_pkg::TS_SRCH_B : kwrs_pkg::TS_FIN;
      end
      kwrs_pkg::TS_SRCH_B: begin
        if (srsp.done) state_nxt = x_en ? kwrs_pkg::TS_SRCH_X : kwrs_pkg::TS_FIN;
      end
      kwrs_pkg::TS_SRCH_X: begin
        if (srsp.done) state_nxt = kwrs_pkg::TS_FIN;
      end
      kwrs_pkg::TS_FIN: begin
        if (fin_go) state_nxt = kwrs_pkg::TS_IDLE;
      end
      default: state_nxt = kwrs_pkg::TS_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall       = (state_r != kwrs_pkg::TS_IDLE) || (ov_r && out_stall);
    fin_go         = (state_r == kwrs_pkg::TS_FIN) && (!ov_r || !out_stall);
    sreq.go        = 1'b0;
    sreq.table_sel = 1'b0;
    unique case (state_r)
      kwrs_pkg::TS_IDLE:   sreq.go = in_acc && lookup_req;
      kwrs_pkg::TS_SRCH_B: begin
        sreq.go        = srsp.done && x_en;
        sreq.table_sel = 1'b1;
      end
      default: ;
    endcase
    s_count = sreq.table_sel ? x_sat : b_sat;
  end

  assign mem_we = (state_r == kwrs_pkg::TS_IDLE) && in_acc && (in_mode == kwrs_pkg::MODE_LOAD)
                  && (CMPW'(in_load_entry) < CMPW'(TABLE_WORDS))
                  && (CMPW'(in_load_position) < CMPW'(WORD_CHARS));
  assign waddr  = (AW'(in_load_table) * AW'(TABLE_WORDS) + AW'(in_load_entry))
                  * AW'(WORD_CHARS) + AW'(in_load_position);

  assign total = XW'(bl_r) + XW'(xl_r);

  // state updates
  always_comb begin
    digits_nxt = digits_r;
    len_nxt    = len_r;
    bs_nxt     = bs_r;
    bl_nxt     = bl_r;
    xs_nxt     = xs_r;
    xl_nxt     = xl_r;
    sel_nxt    = sel_r;
    acc_nxt    = acc_r;
    if (state_r == kwrs_pkg::TS_IDLE && in_acc) begin
      acc_nxt = 1'b1;
      case (in_mode)
        kwrs_pkg::MODE_PUSH: begin
          acc_nxt = push_ok;
          if (push_ok) begin
            digits_nxt[len_r[DIW-1:0]] = in_key_char[kwrs_pkg::DIGIT_W-1:0];
            len_nxt = len_r + LW'(1);
          end
        end
        kwrs_pkg::MODE_POP: begin
          acc_nxt = pop_ok;
          if (pop_ok) begin
            len_nxt = len_r - LW'(1);
            digits_nxt[len_nxt[DIW-1:0]] = '0;
          end
        end
        kwrs_pkg::MODE_NEXT: begin
          if (total != '0)
            sel_nxt = (XW'(sel_r) + XW'(1) == total) ? '0 : sel_r + SW'(1);
        end
        kwrs_pkg::MODE_PREV: begin
          if (total != '0)
            sel_nxt = (sel_r == '0) ? SW'(total - XW'(1)) : sel_r - SW'(1);
        end
        kwrs_pkg::MODE_CLEAR: begin
          digits_nxt = '0;
          len_nxt    = '0;
        end
        kwrs_pkg::MODE_REFRESH,
        kwrs_pkg::MODE_LOAD: ;
        default: acc_nxt = 1'b0;
      endcase
      // every lookup and every emptying starts from no candidates
      if (lookup_req || (in_mode == kwrs_pkg::MODE_CLEAR)
          || (in_mode == kwrs_pkg::MODE_POP && len_r == LW'(1))) begin
        bs_nxt  = '0;
        bl_nxt  = '0;
        xs_nxt  = '0;
        xl_nxt  = '0;
        sel_nxt = '0;
      end
    end
    if (state_r == kwrs_pkg::TS_SRCH_B && srsp.done) begin
      bs_nxt = s_start;
      bl_nxt = s_len;
    end
    if (state_r == kwrs_pkg::TS_SRCH_X && srsp.done) begin
      xs_nxt = s_start;
      xl_nxt = s_len;
    end
  end

  always_comb begin
    sel_x = XW'(sel_r);
    if (sel_x < XW'(bl_r)) ent_x = XW'(bs_r) + sel_x;
    else ent_x = XW'(xs_r) + sel_x - XW'(bl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= kwrs_pkg::TS_IDLE;
      bcnt_r   <= '0;
      xcnt_r   <= '0;
      xen_r    <= 1'b0;
      digits_r <= '0;
      len_r    <= '0;
      bs_r     <= '0;
      bl_r     <= '0;
      xs_r     <= '0;
      xl_r     <= '0;
      sel_r    <= '0;
      acc_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      digits_r <= digits_nxt;
      len_r    <= len_nxt;
      bs_r     <= bs_nxt;
      bl_r     <= bl_nxt;
      xs_r     <= xs_nxt;
      xl_r     <= xl_nxt;
      sel_r    <= sel_nxt;
      acc_r    <= acc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          kwrs_pkg::CFG_BUILTIN_COUNT: bcnt_r <= cfg_wdata;
          kwrs_pkg::CFG_EXTRA_COUNT:   xcnt_r <= cfg_wdata;
          kwrs_pkg::CFG_EXTRA_ENABLE:  xen_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (fin_go) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
    if (fin_go) begin
      o_acc_r  <= acc_r;
      o_dcnt_r <= kwrs_pkg::DCNT_W'(len_r);
      o_cand_r <= kwrs_pkg::CAND_W'(total);
      o_sel_r  <= kwrs_pkg::SEL_W'(sel_r);
      o_has_r  <= (total != '0);
      o_fx_r   <= (total != '0) && (sel_x >= XW'(bl_r));
      o_ent_r  <= (total != '0) ? kwrs_pkg::ENTRY_W'(ent_x) : '0;
    end
  end

  assign out_valid               = ov_r;
  assign out_accepted            = o_acc_r;
  assign out_digit_count         = o_dcnt_r;
  assign out_candidate_count     = o_cand_r;
  assign out_selection           = o_sel_r;
  assign out_has_candidate       = o_has_r;
  assign out_selected_from_extra = o_fx_r;
  assign out_selected_entry      = o_ent_r;

  kwrs_word_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (in_load_char),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  kwrs_search #(
    .MAX_DIGITS  (MAX_DIGITS),
    .TABLE_WORDS (TABLE_WORDS),
    .WORD_CHARS  (WORD_CHARS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (sreq),
    .count     (s_count),
    .digits    (digits_r),
    .len       (len_r),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rsp       (srsp),
    .run_start (s_start),
    .run_len   (s_len)
  );

  `KW_ASSERT(a_sel_in_range, (total != '0) |-> (XW'(sel_r) < total), "selection beyond candidates")
  `KW_ASSERT(a_len_bound, 1'b1 |-> (len_r <= LW'(MAX_DIGITS)), "digit count overflow")
  `KW_ASSERT_NEVER(a_done_unexpected, srsp.done && (state_r == kwrs_pkg::TS_IDLE || state_r == kwrs_pkg::TS_FIN), "search done outside lookup")
  `KW_ASSERT(a_fin_writes, fin_go |=> ov_r, "result not presented")

endmodule
`default_nettype wire

// ===== rtl/kwrs_word_mem.sv =====
// Character store: one write port, one registered read port.
`default_nettype none
module kwrs_word_mem #(
  parameter int AW    = 21,
  parameter int DEPTH = 2097152
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [kwrs_pkg::CHAR_W-1:0]   wdata,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [kwrs_pkg::CHAR_W-1:0]   rdata
);

  logic [kwrs_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [kwrs_pkg::CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/kwrs_search.sv =====
// Lower-bound binary search and run count over one table, reading one character at a time.
`default_nettype none
`include "assert_macros.svh"
module kwrs_search #(
  parameter int MAX_DIGITS  = 24,
  parameter int TABLE_WORDS = 32768,
  parameter int WORD_CHARS  = 32,
  localparam int CW  = $clog2(TABLE_WORDS + 1),
  localparam int LW  = $clog2(MAX_DIGITS + 1),
  localparam int AW  = $clog2(2 * TABLE_WORDS * WORD_CHARS)
) (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire kwrs_pkg::srch_req_t                             req,
  input  wire logic [CW-1:0]                                   count,
  input  wire logic [MAX_DIGITS-1:0][kwrs_pkg::DIGIT_W-1:0]    digits,
  input  wire logic [LW-1:0]                                   len,
  output logic      [AW-1:0]                                   rd_addr,
  input  wire logic [kwrs_pkg::CHAR_W-1:0]                     rd_data,
  output kwrs_pkg::srch_rsp_t                                  rsp,
  output logic      [CW-1:0]                                   run_start,
  output logic      [CW-1:0]                                   run_len
);

  localparam int PW  = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int DIW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  kwrs_pkg::srch_state_t state_r, state_nxt;

  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, n_r, n_nxt, cnt_r, cnt_nxt, ent_r, ent_nxt;
  logic          run_r, run_nxt, tab_r, tab_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [AW-1:0] base_r, base_nxt;

  logic [CW-1:0]               mid, tgt;
  logic                        bs_live, probe_ok;
  logic [kwrs_pkg::DIGIT_W-1:0] d, dig;
  logic                        fin, lt, eq;
  logic [LW-1:0]               k_step;

  // probe choice
  always_comb begin
    mid      = lo_r + ((hi_r - lo_r) >> 1);
    bs_live  = !run_r && (lo_r < hi_r);
    tgt      = bs_live ? mid : lo_r + n_r;
    probe_ok = bs_live || ((lo_r + n_r) < cnt_r);
  end

  // one character of the key compare
  always_comb begin
    d      = kwrs_pkg::key_of_char(rd_data);
    dig    = digits[k_r[DIW-1:0]];
    fin    = 1'b0;
    lt     = 1'b0;
    eq     = 1'b0;
    k_step = k_r;
    if (rd_data == '0) begin
      fin = 1'b1;
      lt  = k_r < len;
      eq  = !lt;
    end else if (d != '0) begin
      if (k_r >= len) begin
        fin = 1'b1;
      end else if (d != dig) begin
        fin = 1'b1;
        lt  = d < dig;
      end else begin
        k_step = k_r + LW'(1);
      end
    end
    if (!fin && p_r == PW'(WORD_CHARS - 1)) begin
      fin = 1'b1;
      lt  = k_step < len;
      eq  = !lt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kwrs_pkg::SR_IDLE,
      kwrs_pkg::SR_DONE: state_nxt = req.go ? kwrs_pkg::SR_PICK : kwrs_pkg::SR_IDLE;
      kwrs_pkg::SR_PICK: state_nxt = probe_ok ? kwrs_pkg::SR_RD : kwrs_pkg::SR_DONE;
      kwrs_pkg::SR_RD:   state_nxt = kwrs_pkg::SR_EV;
      kwrs_pkg::SR_EV: begin
        if (!fin) state_nxt = kwrs_pkg::SR_RD;
        else if (run_r && !eq) state_nxt = kwrs_pkg::SR_DONE;
        else state_nxt = kwrs_pkg::SR_PICK;
      end
      default: state_nxt = kwrs_pkg::SR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state_r == kwrs_pkg::SR_DONE);
    rsp.busy = (state_r != kwrs_pkg::SR_IDLE) && (state_r != kwrs_pkg::SR_DONE);
    rd_addr  = base_r + AW'(p_r);
    run_start = lo_r;
    run_len   = n_r;
  end

  // datapath
  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    n_nxt    = n_r;
    cnt_nxt  = cnt_r;
    ent_nxt  = ent_r;
    run_nxt  = run_r;
    tab_nxt  = tab_r;
    k_nxt    = k_r;
    p_nxt    = p_r;
    base_nxt = base_r;
    case (state_r)
      kwrs_pkg::SR_IDLE,
      kwrs_pkg::SR_DONE: begin
        if (req.go) begin
          lo_nxt  = '0;
          hi_nxt  = count;
          n_nxt   = '0;
          cnt_nxt = count;
          run_nxt = 1'b0;
          tab_nxt = req.table_sel;
        end
      end
      kwrs_pkg::SR_PICK: begin
        if (!bs_live) run_nxt = 1'b1;
        ent_nxt  = tgt;
        k_nxt    = '0;
        p_nxt    = '0;
        base_nxt = (AW'(tab_r) * AW'(TABLE_WORDS) + AW'(tgt)) * AW'(WORD_CHARS);
      end
      kwrs_pkg::SR_EV: begin
        k_nxt = k_step;
        if (!fin) begin
          p_nxt = p_r + PW'(1);
        end else if (!run_r) begin
          if (lt) lo_nxt = ent_r + CW'(1);
          else hi_nxt = ent_r;
        end else if (eq) begin
          n_nxt = n_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwrs_pkg::SR_IDLE;
      run_r   <= 1'b0;
      lo_r    <= '0;
      hi_r    <= '0;
      n_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      n_r     <= n_nxt;
      cnt_r   <= cnt_nxt;
    end
    ent_r  <= ent_nxt;
    tab_r  <= tab_nxt;
    k_r    <= k_nxt;
    p_r    <= p_nxt;
    base_r <= base_nxt;
  end

  `KW_ASSERT(a_lo_le_hi, (state_r != kwrs_pkg::SR_IDLE && !run_r) |-> (lo_r <= hi_r), "search bounds crossed")
  `KW_ASSERT(a_run_bound, run_r |-> ((CW+1)'(lo_r) + (CW+1)'(n_r) <= (CW+1)'(cnt_r)), "run past count")
  `KW_ASSERT(a_k_bound, (state_r == kwrs_pkg::SR_EV) |-> (k_r <= len), "digit index past length")

endmodule
`default_nettype wire
